[rtl/spv_pkg.sv]
// Shared types and constants of the spike peak/valley feature block.
// Used by spv_ctrl, spv_dp and spike_peak_valley_features_top; depends on nothing.
package spv_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int POS_W       = 10;   // signed scan position, covers -512 .. 511
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HALFWIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALLEY_BEFORE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALLEY_AFTER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE     = 3'd5;

    // reset values of the configuration registers
    localparam logic [2:0] RST_NUM_CHANNELS   = 3'd4;
    localparam logic [6:0] RST_PEAK_CENTER    = 7'd64;
    localparam logic [5:0] RST_PEAK_HALFWIDTH = 6'd16;
    localparam logic [3:0] RST_VALLEY_BEFORE  = 4'd7;
    localparam logic [3:0] RST_VALLEY_AFTER   = 4'd7;
    localparam logic [9:0] RST_TIME_SCALE     = 10'd200;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PK_INIT,
        ST_PK_SCAN,
        ST_PK_DRAIN,
        ST_VL_INIT,
        ST_VL_SCAN,
        ST_VL_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PK_INIT,
        OP_PK_SCAN,
        OP_VL_INIT,
        OP_VL_SCAN,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        RD_PK_INIT,
        RD_PK_SCAN,
        RD_VL_INIT,
        RD_VL_SCAN
    } rd_kind_t;

    typedef struct packed {
        op_t  op;
        logic sample_wr;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } sts_t;

endpackage

[rtl/spv_ctrl.sv]
// Sequencer of the spike peak/valley feature block: load, peak scan, valley scan, finish.
// Depends on spv_pkg; drives the command struct of spv_dp.
module spv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  spv_pkg::sts_t sts,
    output spv_pkg::cmd_t cmd
);
    import spv_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.sample_wr = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.sample_wr = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_PK_INIT;
                end
            end
            ST_PK_INIT: begin
                cmd.op     = OP_PK_INIT;
                state_next = ST_PK_SCAN;
            end
            ST_PK_SCAN: begin
                cmd.op = OP_PK_SCAN;
                if (sts.scan_last) begin
                    state_next = ST_PK_DRAIN;
                end
            end
            ST_PK_DRAIN: begin
                state_next = ST_VL_INIT;
            end
            ST_VL_INIT: begin
                cmd.op     = OP_VL_INIT;
                state_next = ST_VL_SCAN;
            end
            ST_VL_SCAN: begin
                cmd.op = OP_VL_SCAN;
                if (sts.scan_last) begin
                    state_next = ST_VL_DRAIN;
                end
            end
            ST_VL_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!sts.out_busy) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[rtl/spv_dp.sv]
// Datapath of the spike peak/valley feature block: configuration registers,
// waveform store, scan counters, min/max tracking and the result register. Depends on spv_pkg.
module spv_dp #(
    parameter int MAX_CHANNELS = 4,
    parameter int WAVE_SAMPLES = 128
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  spv_pkg::cmd_t                          cmd,
    output spv_pkg::sts_t                          sts,
    input  logic signed [spv_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic [1:0]                             s_channel,
    input  logic [6:0]                             s_time,
    input  logic                                   cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [spv_pkg::OUT_DATA_W-1:0]         m_tdata
);
    import spv_pkg::*;

    localparam int DEPTH = MAX_CHANNELS * WAVE_SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(WAVE_SAMPLES);
    localparam int CCW   = $clog2(MAX_CHANNELS + 1);
    localparam logic signed [POS_W-1:0] WAVE_END = POS_W'(WAVE_SAMPLES);

    // configuration
    logic [2:0] num_channels_reg;
    logic [6:0] peak_center_reg;
    logic [5:0] peak_halfwidth_reg;
    logic [3:0] valley_before_reg;
    logic [3:0] valley_after_reg;
    logic [9:0] time_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_channels_reg   <= RST_NUM_CHANNELS;
            peak_center_reg    <= RST_PEAK_CENTER;
            peak_halfwidth_reg <= RST_PEAK_HALFWIDTH;
            valley_before_reg  <= RST_VALLEY_BEFORE;
            valley_after_reg   <= RST_VALLEY_AFTER;
            time_scale_reg     <= RST_TIME_SCALE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_CHANNELS:   num_channels_reg   <= cfg_wdata[2:0];
                CFG_PEAK_CENTER:    peak_center_reg    <= cfg_wdata[6:0];
                CFG_PEAK_HALFWIDTH: peak_halfwidth_reg <= cfg_wdata[5:0];
                CFG_VALLEY_BEFORE:  valley_before_reg  <= cfg_wdata[3:0];
                CFG_VALLEY_AFTER:   valley_after_reg   <= cfg_wdata[3:0];
                CFG_TIME_SCALE:     time_scale_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // waveform store
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_q_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_en;

    assign wr_en   = cmd.sample_wr && (32'(s_channel) < MAX_CHANNELS)
                     && (32'(s_time) < WAVE_SAMPLES);
    assign wr_addr = AW'(32'(s_channel) * WAVE_SAMPLES) + AW'(s_time);

    // scan counters
    logic [CCW-1:0]          nch_reg, ch_reg, nch_sat;
    logic signed [POS_W-1:0] j_reg, start_reg, end_reg;
    logic                    empty_reg;
    logic signed [POS_W-1:0] center_j, pk_start, pk_end, vl_start, vl_end;
    logic signed [POS_W-1:0] ptm_reg, tma_reg, tmb_reg;
    logic                    j_last, ch_last;

    assign nch_sat  = (32'(num_channels_reg) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS)
                                                              : CCW'(num_channels_reg);
    assign center_j = POS_W'(peak_center_reg);
    assign pk_start = center_j - POS_W'(peak_halfwidth_reg);
    assign pk_end   = center_j + POS_W'(peak_halfwidth_reg);
    assign vl_start = ptm_reg - POS_W'(valley_before_reg);
    assign vl_end   = ptm_reg + POS_W'(valley_after_reg);
    assign j_last   = (j_reg == POS_W'(end_reg - 2'sd1));
    assign ch_last  = (ch_reg == CCW'(nch_reg - 1'b1));

    assign sts.scan_last = empty_reg || (j_last && ch_last);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_PK_INIT: begin
                nch_reg   <= nch_sat;
                ch_reg    <= '0;
                j_reg     <= pk_start;
                start_reg <= pk_start;
                end_reg   <= pk_end;
                empty_reg <= (peak_halfwidth_reg == '0) || (nch_sat == '0);
            end
            OP_VL_INIT: begin
                ch_reg    <= '0;
                j_reg     <= vl_start;
                start_reg <= vl_start;
                end_reg   <= vl_end;
                empty_reg <= ((valley_before_reg == '0) && (valley_after_reg == '0))
                             || (nch_reg == '0);
            end
            OP_PK_SCAN, OP_VL_SCAN: begin
                if (j_last) begin
                    j_reg  <= start_reg;
                    ch_reg <= ch_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 2'sd1;
                end
            end
            default: ;
        endcase
    end

    // read issue
    logic [CCW-1:0]          rd_ch;
    logic signed [POS_W-1:0] rd_j;
    logic                    rd_req, rd_use;
    rd_kind_t                rd_kind;

    always_comb begin
        rd_ch   = '0;
        rd_j    = j_reg;
        rd_req  = 1'b0;
        rd_kind = RD_PK_SCAN;
        case (cmd.op)
            OP_PK_INIT: begin
                rd_j    = center_j;
                rd_req  = 1'b1;
                rd_kind = RD_PK_INIT;
            end
            OP_PK_SCAN: begin
                rd_ch   = ch_reg;
                rd_req  = !empty_reg;
                rd_kind = RD_PK_SCAN;
            end
            OP_VL_INIT: begin
                rd_j    = ptm_reg;
                rd_req  = 1'b1;
                rd_kind = RD_VL_INIT;
            end
            OP_VL_SCAN: begin
                rd_ch   = ch_reg;
                rd_req  = !empty_reg;
                rd_kind = RD_VL_SCAN;
            end
            default: ;
        endcase
    end

    // positions outside the store are skipped in the scans and read as zero at init
    assign rd_use  = rd_req && !rd_j[POS_W-1] && (rd_j < WAVE_END);
    assign rd_addr = AW'(32'(rd_ch) * WAVE_SAMPLES) + AW'(rd_j[PW-1:0]);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_sample;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // read tag, registered with the store read so it arrives with the read data
    logic                    rd_valid_reg, rd_use_reg;
    rd_kind_t                rd_kind_reg;
    logic signed [POS_W-1:0] rd_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_req;
        end
        rd_use_reg  <= rd_use;
        rd_kind_reg <= rd_kind;
        rd_j_reg    <= rd_j;
    end

    // min/max tracking
    logic signed [SAMPLE_BITS-1:0] pmin_reg, pm1_reg, pm2_reg, rd_val;

    assign rd_val = rd_use_reg ? mem_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            case (rd_kind_reg)
                RD_PK_INIT: begin
                    pmin_reg <= rd_val;
                    ptm_reg  <= rd_j_reg;
                end
                RD_PK_SCAN: begin
                    if (rd_use_reg && (mem_q_reg < pmin_reg)) begin
                        pmin_reg <= mem_q_reg;
                        ptm_reg  <= rd_j_reg;
                    end
                end
                RD_VL_INIT: begin
                    pm1_reg <= rd_val;
                    pm2_reg <= rd_val;
                    tma_reg <= rd_j_reg;
                    tmb_reg <= rd_j_reg;
                end
                default: begin
                    if (rd_use_reg) begin
                        if (rd_j_reg < ptm_reg) begin
                            if (mem_q_reg > pm1_reg) begin
                                pm1_reg <= mem_q_reg;
                                tma_reg <= rd_j_reg;
                            end
                        end else if (mem_q_reg > pm2_reg) begin
                            pm2_reg <= mem_q_reg;
                            tmb_reg <= rd_j_reg;
                        end
                    end
                end
            endcase
        end
    end

    // features
    logic signed [SAMPLE_BITS:0]   diff1, diff2, half1, half2;
    logic signed [POS_W:0]         tdiff;
    logic signed [POS_W+11:0]      interval;

    assign diff1    = (SAMPLE_BITS+1)'(pmin_reg) - (SAMPLE_BITS+1)'(pm1_reg);
    assign diff2    = (SAMPLE_BITS+1)'(pmin_reg) - (SAMPLE_BITS+1)'(pm2_reg);
    // halve with truncation toward zero
    assign half1    = (diff1 + (SAMPLE_BITS+1)'(diff1[SAMPLE_BITS])) >>> 1;
    assign half2    = (diff2 + (SAMPLE_BITS+1)'(diff2[SAMPLE_BITS])) >>> 1;
    assign tdiff    = (POS_W+1)'(tma_reg) - (POS_W+1)'(tmb_reg);
    assign interval = tdiff * $signed({1'b0, time_scale_reg});

    // result register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_FINISH) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            m_tdata_reg <= {1'b0, interval[15:0], half2[15:0], half1[15:0],
                            pmin_reg[15:0], ptm_reg[6:0]};
        end
    end

    assign sts.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

[rtl/spike_peak_valley_features_top.sv]
// Top level of the spike peak/valley feature block.
// Depends on spv_pkg, spv_ctrl and spv_dp.
//
// Samples of a multichannel spike waveform stream in one per cycle while s_tready
// is high and land in a store of MAX_CHANNELS x WAVE_SAMPLES entries with one write
// and one read port; samples with a channel or position outside the store are
// dropped. A transfer with tlast set stores its sample and starts the search,
// during which s_tready is low. The search runs an init step, a scan over nch
// channels x 2*halfwidth positions and a drain step for the peak, then the same
// for the valleys over nch x (before+after) positions, then a finish step that
// loads the result (an empty window skips its reads); every scan step is one read
// of the store. The result sits in an output register, so loading of the next
// waveform goes on while it waits; only the finish step stalls if the previous
// result is still untaken. Entries never written since reset read as undefined.
module spike_peak_valley_features_top #(
    parameter int MAX_CHANNELS = 4,
    parameter int WAVE_SAMPLES = 128
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_value[15:0], channel_index[17:16], time_index[24:18], zero fill
    input  logic [spv_pkg::IN_DATA_W-1:0]         s_tdata,
    input  logic                                  s_tlast,      // last_sample
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // min_pos[6:0], min_sample[22:7], peak_to_valley_1[38:23],
    // peak_to_valley_2[54:39], valley_interval[70:55], zero fill
    output logic [spv_pkg::OUT_DATA_W-1:0]        m_tdata,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import spv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence load, peak scan, valley scan and finish
    spv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, scan counters, min/max tracking and result register
    spv_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WAVE_SAMPLES (WAVE_SAMPLES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_sample  (s_tdata[15:0]),
        .s_channel (s_tdata[17:16]),
        .s_time    (s_tdata[24:18]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
